/* sv/dhcp_ofe_pkg.sv */
`default_nettype none
package dhcp_ofe_pkg;

	// walk phases of one options area
	typedef enum logic [2:0] {
		PH_COOKIE = 3'd0,
		PH_CODE   = 3'd1,
		PH_LEN    = 3'd2,
		PH_VALUE  = 3'd3,
		PH_SKIP   = 3'd4,
		PH_DRAIN  = 3'd5
	} phase_t;

	// result status codes
	localparam logic [2:0] ST_DATA      = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_NOTFOUND  = 3'd2;
	localparam logic [2:0] ST_BADCOOKIE = 3'd3;
	localparam logic [2:0] ST_TRUNC     = 3'd4;

	// option codes with fixed meaning
	localparam logic [7:0] OPT_PAD  = 8'd0;
	localparam logic [7:0] OPT_END  = 8'd255;
	localparam logic [7:0] OPT_HOST = 8'd12;

	// magic cookie byte by position
	function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0:    b = 8'd99;
			2'd1:    b = 8'd130;
			2'd2:    b = 8'd83;
			default: b = 8'd99;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

/* sv/dhcp_option_field_extractor_top.sv */
// DHCP option field extractor.
// The slave stream carries the options area one byte per beat (cookie first),
// with s_tlast on the area's final byte. The master stream returns the value
// bytes of the option whose code matches the wanted option register, or one
// status beat: tuser holds the status (data, empty option, not found, bad
// cookie, truncated) and tlast marks the final beat of each area.
// The cfg channel writes the wanted option code (reset value 12, host name);
// write it only while no area is in flight. cfg_ready is always high.
// A byte taken into the input register is parsed when the output register is
// free, and its result beat, if any, is registered in the output register.
// Throughput: one byte per cycle while the output register is free, set by the
// combinational parse between the input register and the output register.
// Bytes that give no result still take their turn in the parse.
// Reset clears both registers and returns the parser to the cookie check.
// When the receiver stalls, the output beat holds; one more byte waits in the
// input register, and s_tready drops until the output beat is taken.
`default_nettype none
module dhcp_option_field_extractor_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// configuration write
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data,     // [7:0] wanted_option
	// options area in
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,      // [7:0] data_byte
	input  wire logic       s_tlast,      // area_last
	// extracted bytes out
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,      // [7:0] out_byte
	output logic [2:0]      m_tuser,      // [2:0] status
	output logic            m_tlast       // run_last
);
	import dhcp_ofe_pkg::*;

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic [7:0] wanted_q;
	phase_t     phase_q, phase_d;
	logic [1:0] cidx_q, cidx_d;
	logic [7:0] left_q, left_d;
	logic       hit_q, hit_d;

	logic       out_v_q;
	logic [7:0] out_byte_q;
	logic [2:0] out_st_q;
	logic       out_last_q;

	logic       out_free;
	logic       proc;
	logic       emit;
	logic [7:0] emit_byte;
	logic [2:0] emit_st;
	logic       emit_last;
	logic [7:0] left_dec;

	assign out_free  = !out_v_q || m_tready;
	assign proc      = v_s1 && out_free;
	assign s_tready  = !v_s1 || out_free;
	assign cfg_ready = 1'b1;
	assign left_dec  = left_q - 8'd1;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_q <= OPT_HOST;
		end else if (cfg_valid) begin
			wanted_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// parse step: next state and result for the byte in the input register
	always_comb begin
		phase_d   = phase_q;
		cidx_d    = cidx_q;
		left_d    = left_q;
		hit_d     = hit_q;
		emit      = 1'b0;
		emit_byte = 8'd0;
		emit_st   = ST_NOTFOUND;
		emit_last = 1'b1;
		unique case (phase_q)
			PH_COOKIE: begin
				if (byte_s1 != cookie_byte(cidx_q)) begin
					emit    = 1'b1;
					emit_st = ST_BADCOOKIE;
					phase_d = PH_DRAIN;
				end else if (cidx_q == 2'd3) begin
					phase_d = PH_CODE;
					emit    = last_s1;
					emit_st = ST_NOTFOUND;
				end else begin
					cidx_d  = cidx_q + 2'd1;
					emit    = last_s1;
					emit_st = ST_BADCOOKIE;
				end
			end
			PH_CODE: begin
				if (byte_s1 == OPT_END) begin
					emit    = 1'b1;
					emit_st = ST_NOTFOUND;
					phase_d = PH_DRAIN;
				end else if (byte_s1 == OPT_PAD) begin
					emit    = last_s1;
					emit_st = ST_NOTFOUND;
				end else begin
					hit_d   = (byte_s1 == wanted_q);
					phase_d = PH_LEN;
					emit    = last_s1;
					emit_st = ST_TRUNC;
				end
			end
			PH_LEN: begin
				left_d = byte_s1;
				if (hit_q) begin
					if (byte_s1 == 8'd0) begin
						emit    = 1'b1;
						emit_st = ST_EMPTY;
						phase_d = PH_DRAIN;
					end else begin
						phase_d = PH_VALUE;
						emit    = last_s1;
						emit_st = ST_TRUNC;
					end
				end else if (byte_s1 == 8'd0) begin
					phase_d = PH_CODE;
					emit    = last_s1;
					emit_st = ST_NOTFOUND;
				end else begin
					phase_d = PH_SKIP;
					emit    = last_s1;
					emit_st = ST_TRUNC;
				end
			end
			PH_VALUE: begin
				left_d = left_dec;
				emit   = 1'b1;
				if (left_dec == 8'd0) begin
					emit_byte = byte_s1;
					emit_st   = ST_DATA;
					phase_d   = PH_DRAIN;
				end else if (last_s1) begin
					emit_st = ST_TRUNC;
				end else begin
					emit_byte = byte_s1;
					emit_st   = ST_DATA;
					emit_last = 1'b0;
				end
			end
			PH_SKIP: begin
				left_d = left_dec;
				if (left_dec == 8'd0) begin
					phase_d = PH_CODE;
					emit    = last_s1;
					emit_st = ST_NOTFOUND;
				end else begin
					emit    = last_s1;
					emit_st = ST_TRUNC;
				end
			end
			PH_DRAIN: begin
				emit = 1'b0;
			end
			default: begin
				phase_d = PH_DRAIN;
			end
		endcase
		// end of area restarts the walk
		if (last_s1) begin
			phase_d = PH_COOKIE;
			cidx_d  = 2'd0;
			left_d  = 8'd0;
			hit_d   = 1'b0;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COOKIE;
			cidx_q  <= 2'd0;
			left_q  <= 8'd0;
			hit_q   <= 1'b0;
		end else if (proc) begin
			phase_q <= phase_d;
			cidx_q  <= cidx_d;
			left_q  <= left_d;
			hit_q   <= hit_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (proc && emit) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			out_byte_q <= emit_byte;
			out_st_q   <= emit_st;
			out_last_q <= emit_last;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_st_q;
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

/* sv/dhcp_ofe_chk.sv */
`default_nettype none
module dhcp_ofe_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic [2:0] m_tuser,
	input wire logic       m_tlast
);
	import dhcp_ofe_pkg::*;

	// only defined status codes leave the block
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_DATA || m_tuser == ST_EMPTY ||
			m_tuser == ST_NOTFOUND || m_tuser == ST_BADCOOKIE || m_tuser == ST_TRUNC))
		else $error("undefined status on output beat");

	// status beats always close the area
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_DATA) |-> m_tlast)
		else $error("status beat without tlast");

	// status beats carry a zero byte
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_DATA) |-> (m_tdata == 8'd0))
		else $error("status beat with nonzero data");

	// a stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) &&
			$stable(m_tuser) && $stable(m_tlast)))
		else $error("output beat changed while stalled");

endmodule

bind dhcp_option_field_extractor_top dhcp_ofe_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
	import dhcp_ofe_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned BYTES_PER_SETTING = 220;
	// magic cookie, position 0 in the low byte
	localparam logic [3:0][7:0] COOKIE = {8'd99, 8'd83, 8'd130, 8'd99};

	// one result beat as seen on the master side
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [2:0] status;
	} beat_t;

	localparam beat_t NO_BEAT = '{8'h00, 1'b0, ST_DATA};

	// directed stimulus row: byte, area end, typed result (if any)
	typedef struct {
		logic [7:0] b;
		logic       last;
		bit         typed;
		beat_t      want;
	} row_t;

	// receiver stall patterns
	typedef enum logic [1:0] {
		RX_FREE,
		RX_MOSTLY,
		RX_SPARSE,
		RX_EVERY3
	} rx_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = 8'h00;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [2:0] m_tuser;
	logic       m_tlast;

	dhcp_option_field_extractor_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// parser shadow state
	phase_t     ph = PH_COOKIE;
	logic [1:0] ck_idx = 2'd0;
	logic [7:0] left = 8'd0;
	logic       hit = 1'b0;
	logic [7:0] wanted = OPT_HOST;

	beat_t       beats_due [$];
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned burst_left = 0;
	int unsigned rx_win = 0;
	rx_mode_t    rx_mode = RX_FREE;

	row_t plan [29] = '{
		// wrong first cookie byte, one-byte area
		'{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b1, ST_BADCOOKIE}},
		// area ends inside the cookie
		'{8'd99, 1'b0, 1'b0, NO_BEAT},
		'{8'd130, 1'b1, 1'b1, '{8'h00, 1'b1, ST_BADCOOKIE}},
		// pad, zero-length option, skipped option, host name cut short
		'{8'd99, 1'b0, 1'b0, NO_BEAT},
		'{8'd130, 1'b0, 1'b0, NO_BEAT},
		'{8'd83, 1'b0, 1'b0, NO_BEAT},
		'{8'd99, 1'b0, 1'b0, NO_BEAT},
		'{OPT_PAD, 1'b0, 1'b0, NO_BEAT},
		'{8'd7, 1'b0, 1'b0, NO_BEAT},
		'{8'd0, 1'b0, 1'b0, NO_BEAT},
		'{8'd50, 1'b0, 1'b0, NO_BEAT},
		'{8'd1, 1'b0, 1'b0, NO_BEAT},
		'{8'hAA, 1'b0, 1'b0, NO_BEAT},
		'{OPT_HOST, 1'b0, 1'b0, NO_BEAT},
		'{8'd3, 1'b0, 1'b0, NO_BEAT},
		'{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, ST_DATA}},
		'{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b1, ST_TRUNC}},
		// empty host name, rest of area drained
		'{8'd99, 1'b0, 1'b0, NO_BEAT},
		'{8'd130, 1'b0, 1'b0, NO_BEAT},
		'{8'd83, 1'b0, 1'b0, NO_BEAT},
		'{8'd99, 1'b0, 1'b0, NO_BEAT},
		'{OPT_HOST, 1'b0, 1'b0, NO_BEAT},
		'{8'd0, 1'b0, 1'b1, '{8'h00, 1'b1, ST_EMPTY}},
		'{OPT_END, 1'b1, 1'b0, NO_BEAT},
		// end code right after the cookie
		'{8'd99, 1'b0, 1'b0, NO_BEAT},
		'{8'd130, 1'b0, 1'b0, NO_BEAT},
		'{8'd83, 1'b0, 1'b0, NO_BEAT},
		'{8'd99, 1'b0, 1'b0, NO_BEAT},
		'{OPT_END, 1'b1, 1'b1, '{8'h00, 1'b1, ST_NOTFOUND}}
	};

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver stalls, pattern changes per window
	always @(negedge clk) begin
		if (rx_win == 0) begin
			rx_win = $urandom_range(16, 80);
			rx_mode = rx_mode_t'($urandom_range(0, 3));
		end
		rx_win--;
		case (rx_mode)
			RX_FREE:   m_tready = 1'b1;
			RX_MOSTLY: m_tready = ($urandom_range(0, 3) != 0);
			RX_SPARSE: m_tready = ($urandom_range(0, 3) == 0);
			default:   m_tready = (cycles % 3 != 0);
		endcase
	end

	function automatic beat_t status_beat(input logic [2:0] st);
		return '{8'h00, 1'b1, st};
	endfunction

	// advance the shadow parser by one byte; got marks a result
	task automatic parse_byte(input logic [7:0] b, input logic last,
	                          output bit got, output beat_t res);
		got = 1'b0;
		res = NO_BEAT;
		case (ph)
			PH_COOKIE: begin
				if (b != COOKIE[ck_idx]) begin
					got = 1'b1;
					res = status_beat(ST_BADCOOKIE);
					ph = PH_DRAIN;
				end else if (ck_idx == 2'd3) begin
					ph = PH_CODE;
					got = last;
					res = status_beat(ST_NOTFOUND);
				end else begin
					ck_idx++;
					got = last;
					res = status_beat(ST_BADCOOKIE);
				end
			end
			PH_CODE: begin
				if (b == OPT_END) begin
					got = 1'b1;
					res = status_beat(ST_NOTFOUND);
					ph = PH_DRAIN;
				end else if (b == OPT_PAD) begin
					got = last;
					res = status_beat(ST_NOTFOUND);
				end else begin
					hit = (b == wanted);
					ph = PH_LEN;
					got = last;
					res = status_beat(ST_TRUNC);
				end
			end
			PH_LEN: begin
				left = b;
				if (hit && b == 8'd0) begin
					got = 1'b1;
					res = status_beat(ST_EMPTY);
					ph = PH_DRAIN;
				end else if (b == 8'd0) begin
					ph = PH_CODE;
					got = last;
					res = status_beat(ST_NOTFOUND);
				end else begin
					ph = hit ? PH_VALUE : PH_SKIP;
					got = last;
					res = status_beat(ST_TRUNC);
				end
			end
			PH_VALUE: begin
				left--;
				got = 1'b1;
				if (left == 8'd0) begin
					res = '{b, 1'b1, ST_DATA};
					ph = PH_DRAIN;
				end else if (last) begin
					res = status_beat(ST_TRUNC);
				end else begin
					res = '{b, 1'b0, ST_DATA};
				end
			end
			PH_SKIP: begin
				left--;
				if (left == 8'd0) begin
					ph = PH_CODE;
					got = last;
					res = status_beat(ST_NOTFOUND);
				end else begin
					got = last;
					res = status_beat(ST_TRUNC);
				end
			end
			default: ;
		endcase
		// area end always restarts at the cookie
		if (last) begin
			ph = PH_COOKIE;
			ck_idx = 2'd0;
			left = 8'd0;
			hit = 1'b0;
		end
	endtask

	// send one byte in bursts with random gaps; log its result if any
	task automatic send_byte(input logic [7:0] b, input logic last,
	                         input bit typed, input beat_t want);
		bit          got;
		beat_t       pred;
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		s_tvalid = 1'b1;
		s_tdata = b;
		s_tlast = last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		parse_byte(b, last, got, pred);
		if (typed)
			beats_due.push_back(want);
		else if (got)
			beats_due.push_back(pred);
		burst_left--;
		@(negedge clk);
	endtask

	// wait for all results, then for the pipeline to empty
	task automatic settle();
		s_tvalid = 1'b0;
		s_tlast = 1'b0;
		while (beats_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (beats_due.size() == 0) begin
				$display("%0t: unexpected beat data %02h last %0d status %0d",
				         $time, m_tdata, m_tlast, m_tuser);
				errors++;
			end else begin
				want = beats_due.pop_front();
				if (m_tdata !== want.data || m_tlast !== want.last ||
				    m_tuser !== want.status) begin
					$display("%0t: expected data %02h last %0d status %0d, got data %02h last %0d status %0d",
					         $time, want.data, want.last, want.status,
					         m_tdata, m_tlast, m_tuser);
					errors++;
				end
			end
		end
	end

	// stimulus
	initial begin
		logic [7:0]  setting [7];
		logic [7:0]  area_q [$];
		logic [7:0]  code;
		int unsigned sent;
		int unsigned len;
		int unsigned cut;
		int unsigned kind;

		setting = '{OPT_HOST, 8'd1, 8'd254, OPT_PAD, OPT_END,
		            8'($urandom_range(2, 253)), OPT_HOST};

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed areas with the reset value of the wanted code
		foreach (plan[i])
			send_byte(plan[i].b, plan[i].last, plan[i].typed, plan[i].want);

		for (int p = 0; p < 7; p++) begin
			// the first setting is the reset value, left unwritten
			if (p > 0) begin
				settle();
				cfg_valid = 1'b1;
				cfg_data = setting[p];
				@(posedge clk);
				while (!cfg_ready)
					@(posedge clk);
				wanted = setting[p];
				@(negedge clk);
				cfg_valid = 1'b0;
			end
			sent = 0;
			while (sent < BYTES_PER_SETTING) begin
				area_q.delete();
				kind = $urandom_range(0, 9);
				if (kind == 0) begin
					// noise area
					len = $urandom_range(1, 8);
					repeat (len) area_q.push_back(8'($urandom));
				end else begin
					for (int i = 0; i < 4; i++)
						area_q.push_back(COOKIE[i]);
					if (kind == 1)
						area_q[$urandom_range(0, 3)] = 8'($urandom);
					repeat ($urandom_range(0, 3)) begin
						case ($urandom_range(0, 9))
							0:       code = OPT_PAD;
							1, 2, 3: code = wanted;
							default: code = 8'($urandom_range(1, 254));
						endcase
						area_q.push_back(code);
						if (code != OPT_PAD) begin
							if ($urandom_range(0, 49) == 0)
								len = $urandom_range(20, 255);
							else if ($urandom_range(0, 5) == 0)
								len = 0;
							else
								len = $urandom_range(1, 6);
							area_q.push_back(8'(len));
							repeat (len) area_q.push_back(8'($urandom));
						end
					end
					// end code with trailing bytes, or none
					if ($urandom_range(0, 2) != 0) begin
						area_q.push_back(OPT_END);
						repeat ($urandom_range(0, 3)) area_q.push_back(8'($urandom));
					end
					// cut the area short at a random byte
					if ($urandom_range(0, 3) == 0 && area_q.size() > 1) begin
						cut = $urandom_range(1, area_q.size() - 1);
						while (area_q.size() > cut)
							void'(area_q.pop_back());
					end
				end
				foreach (area_q[i])
					send_byte(area_q[i], i == area_q.size() - 1, 1'b0, NO_BEAT);
				sent += area_q.size();
			end
		end

		settle();
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* dhcp_option_field_extractor_top.f */
sv/dhcp_ofe_pkg.sv
sv/dhcp_option_field_extractor_top.sv
sv/dhcp_ofe_chk.sv
tb/testbench.sv
